>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/cbm_irq_pkg.sv
`timescale 1ns / 1ps

package cbm_irq_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_VIDEO     = 2'd1,
    OP_CPU_CYCLE = 2'd2
  } cbm_op_t;

  // Register decode: {addr[14:13], addr[0]} of an access at or above 0x8000
  typedef enum logic [2:0] {
    REG_SELECT   = 3'b000,
    REG_BANK     = 3'b001,
    REG_MIRROR   = 3'b010,
    REG_UNUSED   = 3'b011,
    REG_RELOAD   = 3'b100,
    REG_IRQ_CTRL = 3'b101,
    REG_IRQ_OFF  = 3'b110,
    REG_IRQ_ON   = 3'b111
  } cbm_reg_t;

  localparam logic [3:0] HOLDOFF_RELOAD  = 4'd8;
  localparam logic [1:0] IRQ_DELAY_START = 2'd3;
  localparam logic [7:0] PRESCALE_RELOAD = 8'd4;
  localparam logic [7:0] FIXED_PRG_BANK  = 8'hFF;

  localparam int NUM_PRG = 3;
  localparam int NUM_CHR = 8;

  typedef struct packed {
    logic       to_chr;
    logic       to_prg;
    logic [2:0] idx;
  } bank_target_t;

  // Where a bank data write lands for a given select code
  function automatic bank_target_t bank_target(input logic [3:0] sel);
    bank_target_t t;
    t = '0;
    case (sel)
      4'h0: begin t.to_chr = 1'b1; t.idx = 3'd0; end
      4'h1: begin t.to_chr = 1'b1; t.idx = 3'd2; end
      4'h2: begin t.to_chr = 1'b1; t.idx = 3'd4; end
      4'h3: begin t.to_chr = 1'b1; t.idx = 3'd5; end
      4'h4: begin t.to_chr = 1'b1; t.idx = 3'd6; end
      4'h5: begin t.to_chr = 1'b1; t.idx = 3'd7; end
      4'h6: begin t.to_prg = 1'b1; t.idx = 3'd0; end
      4'h7: begin t.to_prg = 1'b1; t.idx = 3'd1; end
      4'h8: begin t.to_chr = 1'b1; t.idx = 3'd1; end
      4'h9: begin t.to_chr = 1'b1; t.idx = 3'd3; end
      4'hF: begin t.to_prg = 1'b1; t.idx = 3'd2; end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/cartridge_bank_mapper_irq.sv
`timescale 1ns / 1ps

// Cartridge bank mapper with an A12- or CPU-clocked scanline IRQ counter. Each item is
// a CPU register write, a video bus cycle or a CPU cycle (in_tuser); every item yields
// exactly one result giving the IRQ line, mirroring and the program/character banks
// mapped at the item's addresses, as they stand after the item. Items pass the input
// register, then the result register, and one item is accepted every cycle unless the
// result side stalls; the whole state update and bank lookup is one combinational pass
// between the two registers. A stalled result register backs up into the input register,
// and in_tready drops only when both hold an item. No clearing pass is needed after reset.
module cartridge_bank_mapper_irq_core
  import cbm_irq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cpu_addr[15:0], wdata[23:16], vid_addr[37:24], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // irq_line[0], mirror_mode[1], prg_bank[9:2],
                                  // chr_bank[17:10], zero pad
  output logic        out_tuser   // prg_valid[0]
);

  // input register
  logic        s1_valid_r;
  cbm_op_t     s1_op_r;
  logic [15:0] s1_caddr_r;
  logic [7:0]  s1_wdata_r;
  logic [13:0] s1_vaddr_r;

  // result register
  logic        out_valid_r;
  logic        irq_line_r, mirror_mode_r, prg_valid_r;
  logic [7:0]  prg_bank_r, chr_bank_r;

  // mapper state
  logic [7:0] mode_sel_r,   mode_sel_nxt;
  logic       mirror_r,     mirror_nxt;
  logic [7:0] prg_banks_r [NUM_PRG];
  logic [7:0] prg_banks_nxt [NUM_PRG];
  logic [7:0] chr_banks_r [NUM_CHR];
  logic [7:0] chr_banks_nxt [NUM_CHR];
  logic       cnt_src_r,    cnt_src_nxt;
  logic [7:0] reload_r,     reload_nxt;
  logic       reload_pend_r, reload_pend_nxt;
  logic       irq_en_r,     irq_en_nxt;
  logic [7:0] line_cnt_r,   line_cnt_nxt;
  logic [7:0] prescale_r,   prescale_nxt;
  logic [3:0] holdoff_r,    holdoff_nxt;
  logic [1:0] irq_dly_r,    irq_dly_nxt;
  logic       irq_r,        irq_nxt;

  logic         advance;
  logic         cnt_tick, cpu_tick;
  logic [3:0]   hold_dec;
  logic [7:0]   pre_dec;
  logic         a12;
  bank_target_t tgt;
  cbm_reg_t     reg_sel;

  logic        prg_valid_nxt;
  logic [7:0]  prg_bank_nxt, chr_bank_nxt;
  logic [1:0]  prg_slot;
  logic [2:0]  chr_slot;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= cbm_op_t'(in_tuser);
      s1_caddr_r <= in_tdata[15:0];
      s1_wdata_r <= in_tdata[23:16];
      s1_vaddr_r <= in_tdata[37:24];
    end
  end

  assign a12     = s1_vaddr_r[12];
  assign tgt     = bank_target(mode_sel_r[3:0]);
  assign reg_sel = cbm_reg_t'({s1_caddr_r[14:13], s1_caddr_r[0]});

  always_comb begin
    mode_sel_nxt    = mode_sel_r;
    mirror_nxt      = mirror_r;
    prg_banks_nxt   = prg_banks_r;
    chr_banks_nxt   = chr_banks_r;
    cnt_src_nxt     = cnt_src_r;
    reload_nxt      = reload_r;
    reload_pend_nxt = reload_pend_r;
    irq_en_nxt      = irq_en_r;
    line_cnt_nxt    = line_cnt_r;
    prescale_nxt    = prescale_r;
    holdoff_nxt     = holdoff_r;
    irq_dly_nxt     = irq_dly_r;
    irq_nxt         = irq_r;
    cnt_tick        = 1'b0;
    cpu_tick        = 1'b0;
    hold_dec        = (holdoff_r != 4'd0) ? holdoff_r - 4'd1 : 4'd0;
    pre_dec         = prescale_r - 8'd1;

    if (advance) begin
      case (s1_op_r)
        OP_CPU_WRITE: begin
          if (s1_caddr_r[15]) begin
            unique case (reg_sel)
              REG_SELECT: mode_sel_nxt = s1_wdata_r;
              REG_BANK: begin
                if (tgt.to_chr) begin
                  chr_banks_nxt[tgt.idx] = s1_wdata_r;
                end else if (tgt.to_prg) begin
                  prg_banks_nxt[tgt.idx[1:0]] = s1_wdata_r;
                end
              end
              REG_MIRROR: mirror_nxt = ~s1_wdata_r[0];
              REG_UNUSED: ;
              REG_RELOAD: reload_nxt = s1_wdata_r;
              REG_IRQ_CTRL: begin
                cnt_src_nxt     = s1_wdata_r[0];
                line_cnt_nxt    = 8'd0;
                reload_pend_nxt = 1'b1;
              end
              REG_IRQ_OFF: begin
                irq_en_nxt = 1'b0;
                irq_nxt    = 1'b0;
              end
              REG_IRQ_ON: irq_en_nxt = 1'b1;
              default: ;
            endcase
          end
        end
        OP_VIDEO: begin
          if (!cnt_src_r) begin
            if (irq_dly_r != 2'd0) begin
              irq_dly_nxt = irq_dly_r - 2'd1;
              if (irq_dly_r == 2'd1) begin
                irq_nxt = 1'b1;
              end
            end
            holdoff_nxt = hold_dec;
            if (hold_dec == 4'd0 && a12) begin
              cnt_tick = 1'b1;
            end
            if (a12) begin
              holdoff_nxt = HOLDOFF_RELOAD;
            end
          end
        end
        OP_CPU_CYCLE: begin
          if (cnt_src_r) begin
            prescale_nxt = pre_dec;
            if (pre_dec == 8'd0) begin
              prescale_nxt = PRESCALE_RELOAD;
              cnt_tick     = 1'b1;
              cpu_tick     = 1'b1;
            end
          end
        end
        default: ;
      endcase

      // counter clock; a write item never ticks, so the _r values are current here
      if (cnt_tick) begin
        if (line_cnt_r == 8'd0 || reload_pend_r) begin
          line_cnt_nxt = reload_r;
        end else begin
          line_cnt_nxt = line_cnt_r - 8'd1;
        end
        if ((line_cnt_r != 8'd0 || reload_pend_r) && line_cnt_nxt == 8'd0 && irq_en_r) begin
          irq_dly_nxt = IRQ_DELAY_START;
        end
        reload_pend_nxt = 1'b0;
      end
      // CPU-clocked mode raises the IRQ at once
      if (cpu_tick && irq_dly_nxt != 2'd0) begin
        irq_dly_nxt = 2'd0;
        irq_nxt     = 1'b1;
      end
    end
  end

  // lookups on the state left by the item
  assign prg_slot = s1_caddr_r[14:13];
  assign chr_slot = s1_vaddr_r[12:10] ^ {mode_sel_nxt[7], 2'b00};

  always_comb begin
    prg_valid_nxt = s1_caddr_r[15];
    prg_bank_nxt  = 8'd0;
    if (s1_caddr_r[15]) begin
      if (prg_slot == 2'd3) begin
        prg_bank_nxt = FIXED_PRG_BANK;
      end else if (mode_sel_nxt[6]) begin
        case (prg_slot)
          2'd0:    prg_bank_nxt = prg_banks_nxt[2];
          2'd1:    prg_bank_nxt = prg_banks_nxt[0];
          default: prg_bank_nxt = prg_banks_nxt[1];
        endcase
      end else begin
        prg_bank_nxt = prg_banks_nxt[prg_slot];
      end
    end

    // 2K mode: low half pairs banks 0/1 and 2/3 from the even register
    if (!mode_sel_nxt[5] && !chr_slot[2]) begin
      chr_bank_nxt = {chr_banks_nxt[{1'b0, chr_slot[1], 1'b0}][7:1], chr_slot[0]};
    end else begin
      chr_bank_nxt = chr_banks_nxt[chr_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_sel_r    <= 8'd0;
      mirror_r      <= 1'b0;
      for (int i = 0; i < NUM_PRG; i++) prg_banks_r[i] <= 8'hFF;
      for (int i = 0; i < NUM_CHR; i++) chr_banks_r[i] <= 8'(i);
      cnt_src_r     <= 1'b0;
      reload_r      <= 8'd0;
      reload_pend_r <= 1'b0;
      irq_en_r      <= 1'b0;
      line_cnt_r    <= 8'd0;
      prescale_r    <= 8'd0;
      holdoff_r     <= 4'd0;
      irq_dly_r     <= 2'd0;
      irq_r         <= 1'b0;
    end else begin
      mode_sel_r    <= mode_sel_nxt;
      mirror_r      <= mirror_nxt;
      prg_banks_r   <= prg_banks_nxt;
      chr_banks_r   <= chr_banks_nxt;
      cnt_src_r     <= cnt_src_nxt;
      reload_r      <= reload_nxt;
      reload_pend_r <= reload_pend_nxt;
      irq_en_r      <= irq_en_nxt;
      line_cnt_r    <= line_cnt_nxt;
      prescale_r    <= prescale_nxt;
      holdoff_r     <= holdoff_nxt;
      irq_dly_r     <= irq_dly_nxt;
      irq_r         <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq_line_r    <= irq_nxt;
      mirror_mode_r <= mirror_nxt;
      prg_valid_r   <= prg_valid_nxt;
      prg_bank_r    <= prg_bank_nxt;
      chr_bank_r    <= chr_bank_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, chr_bank_r, prg_bank_r, mirror_mode_r, irq_line_r};
  assign out_tuser  = prg_valid_r;

endmodule

>>> hw/rtl/cbm_irq_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbm_irq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // a held result keeps its payload
  `ASSERT_CLKD(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "result changed while stalled")

  // no program window means a zero bank
  `ASSERT_CLKD(a_prg_zero, out_tvalid && !out_tuser |-> out_tdata[9:2] == 8'd0,
    "bank set outside program window")

  // reset empties the result register
  `ASSERT_CLK(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // reset leaves the input side ready
  `ASSERT_CLK(a_rst_ready, !rst_n |=> in_tready, "input not ready after reset")

  // the high padding stays zero
  `ASSERT_CLKD(a_pad_zero, out_tvalid |-> out_tdata[23:18] == 6'd0, "result padding not zero")

endmodule

bind cartridge_bank_mapper_irq_core cbm_irq_chk u_cbm_irq_chk (.*);
